// ===== hw/rtl/ssdu_pkg.sv =====
// Shared types, constants and the step index table of the saturating state decay update core.
// Used by every module under hw/rtl; depends on nothing else.
package ssdu_pkg;

   // Grid size defaults.
   localparam int ROWS_DEF = 128;
   localparam int COLS_DEF = 16;

   // Field widths and arithmetic constants.
   localparam int STATE_W   = 8;
   localparam int GAIN_W    = 7;
   localparam int ENERGY_W  = 18;
   localparam int MOD_W     = 5;
   localparam int ROW_MOD   = 30;
   localparam int COL_MOD   = 10;
   localparam int STATE_MAX = 127;
   localparam int GRP_LANES = 8;
   localparam int GRP_W     = 10;

   // Register reset values.
   localparam logic [GAIN_W-1:0] DECAY_RESET = 7'd70;
   localparam logic [GAIN_W-1:0] INPUT_RESET = 7'd20;

   // Register index, taken from the word address.
   typedef enum logic {
      REG_DECAY_BASE = 1'b0,
      REG_INPUT_BASE = 1'b1
   } reg_idx_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } seq_state_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic busy;
      logic accept;
      logic rd_en;
      logic wr_en;
      logic acc_en;
      logic finish;
      logic primed;
   } seq_ctrl_type;

   // trunc(50 * sin(0.1 * k)) for k = 0..128.
   localparam logic signed [7:0] SINE_MAG [129] = '{
        8'sd0,   8'sd4,   8'sd9,   8'sd14,  8'sd19,  8'sd23,  8'sd28,  8'sd32,  8'sd35,  8'sd39,
       8'sd42,  8'sd44,  8'sd46,  8'sd48,  8'sd49,  8'sd49,  8'sd49,  8'sd49,  8'sd48,  8'sd47,
       8'sd45,  8'sd43,  8'sd40,  8'sd37,  8'sd33,  8'sd29,  8'sd25,  8'sd21,  8'sd16,  8'sd11,
        8'sd7,   8'sd2,  -8'sd2,  -8'sd7, -8'sd12, -8'sd17, -8'sd22, -8'sd26, -8'sd30, -8'sd34,
      -8'sd37, -8'sd40, -8'sd43, -8'sd45, -8'sd47, -8'sd48, -8'sd49, -8'sd49, -8'sd49, -8'sd49,
      -8'sd47, -8'sd46, -8'sd44, -8'sd41, -8'sd38, -8'sd35, -8'sd31, -8'sd27, -8'sd23, -8'sd18,
      -8'sd13,  -8'sd9,  -8'sd4,   8'sd0,   8'sd5,  8'sd10,  8'sd15,  8'sd20,  8'sd24,  8'sd28,
       8'sd32,  8'sd36,  8'sd39,  8'sd42,  8'sd44,  8'sd46,  8'sd48,  8'sd49,  8'sd49,  8'sd49,
       8'sd49,  8'sd48,  8'sd47,  8'sd45,  8'sd42,  8'sd39,  8'sd36,  8'sd33,  8'sd29,  8'sd25,
       8'sd20,  8'sd15,  8'sd11,   8'sd6,   8'sd1,  -8'sd3,  -8'sd8, -8'sd13, -8'sd18, -8'sd22,
      -8'sd27, -8'sd31, -8'sd34, -8'sd38, -8'sd41, -8'sd43, -8'sd46, -8'sd47, -8'sd49, -8'sd49,
      -8'sd49, -8'sd49, -8'sd48, -8'sd47, -8'sd45, -8'sd43, -8'sd41, -8'sd38, -8'sd34, -8'sd30,
      -8'sd26, -8'sd22, -8'sd17, -8'sd13,  -8'sd8,  -8'sd3,   8'sd1,   8'sd6,  8'sd11
   };

   // Step index: 128 plus the odd-symmetric sine offset, kept to 8 bits.
   function automatic logic [7:0] step_lookup(input logic signed [7:0] x);
      logic [7:0] mag_idx;
      logic [7:0] off;
      mag_idx = x[7] ? 8'(-x) : 8'(x);
      off     = 8'(SINE_MAG[mag_idx]);
      return x[7] ? 8'(8'd128 - off) : 8'(8'd128 + off);
   endfunction

endpackage

// ===== hw/rtl/ssdu_state_mem.sv =====
// Hidden state store: one row of COLS signed 8-bit states per address.
// One write port and one registered read port; uses ssdu_pkg.
module ssdu_state_mem import ssdu_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [ROW_W-1:0]           rd_row,
   input  logic                       wr_en,
   input  logic [ROW_W-1:0]           wr_row,
   input  logic [COLS*STATE_W-1:0]    wr_data,
   output logic [COLS*STATE_W-1:0]    rd_data
);

   logic [COLS*STATE_W-1:0] mem [ROWS];
   logic [COLS*STATE_W-1:0] rd_data_ff;

   // Write back the updated row.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   // Register the read row.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ssdu_row_unit.sv =====
// Shared row update unit: decays and drives one row of states per cycle and
// sums their magnitudes through a two-level registered tree; uses ssdu_pkg.
module ssdu_row_unit import ssdu_pkg::*; #(
   parameter int COLS = COLS_DEF,
   localparam int SUM_W = $clog2(COLS * STATE_MAX + 1),
   localparam int NGRP  = (COLS + GRP_LANES - 1) / GRP_LANES
) (
   input  logic                       clock,
   input  logic [COLS*STATE_W-1:0]    h_row,
   input  logic                       primed,
   input  logic [GAIN_W-1:0]          decay_base,
   input  logic [GAIN_W-1:0]          input_base,
   input  logic signed [7:0]          sample,
   input  logic [MOD_W-1:0]           upd_mod,
   output logic [COLS*STATE_W-1:0]    new_row,
   output logic [SUM_W-1:0]           row_sum
);

   localparam logic signed [10:0] V_MAX = 11'(STATE_MAX);
   localparam logic signed [10:0] V_MIN = -11'(STATE_MAX);

   logic [7:0]                dgain;
   wire  [COLS*STATE_W-1:0]   new_row_in;
   logic [COLS*STATE_W-1:0]   new_row_ff;
   logic [GRP_W-1:0]          grp_sum_in [NGRP];
   logic [GRP_W-1:0]          grp_sum_ff [NGRP];
   logic [SUM_W-1:0]          row_sum_in;
   logic [SUM_W-1:0]          row_sum_ff;

   // Decay gain of the current row.
   assign dgain = {1'b0, decay_base} + {3'b000, upd_mod};

   // One lane per column: two floored products, add, clamp.
   for (genvar c = 0; c < COLS; c++) begin : g_lane
      localparam logic [3:0] CMOD = 4'(c % COL_MOD);
      logic signed [7:0]  h;
      logic [7:0]         igain;
      logic signed [16:0] pd;
      logic signed [16:0] pi;
      logic signed [9:0]  td;
      logic signed [9:0]  ti;
      logic signed [10:0] v;

      assign h     = primed ? $signed(h_row[c*STATE_W +: STATE_W]) : 8'sd0;
      assign igain = {1'b0, input_base} + {4'b0000, CMOD};
      assign pd    = $signed({1'b0, dgain}) * h;
      assign pi    = $signed({1'b0, igain}) * sample;
      assign td    = pd[16:7];
      assign ti    = pi[16:7];
      assign v     = {td[9], td} + {ti[9], ti};
      assign new_row_in[c*STATE_W +: STATE_W] =
         (v > V_MAX) ? 8'(V_MAX) : ((v < V_MIN) ? 8'(V_MIN) : v[7:0]);
   end

   // Sum magnitudes in groups of eight lanes.
   always_comb begin
      int idx;
      logic [7:0] lane_v;
      logic [6:0] mag;
      idx    = 0;
      lane_v = '0;
      mag    = '0;
      for (int g = 0; g < NGRP; g++) begin
         grp_sum_in[g] = '0;
         for (int k = 0; k < GRP_LANES; k++) begin
            idx = g * GRP_LANES + k;
            if (idx < COLS) begin
               lane_v        = new_row_ff[idx*STATE_W +: STATE_W];
               mag           = lane_v[7] ? 7'(-lane_v) : lane_v[6:0];
               grp_sum_in[g] = grp_sum_in[g] + {3'b000, mag};
            end
         end
      end
   end

   // Add the group sums.
   always_comb begin
      row_sum_in = '0;
      for (int g = 0; g < NGRP; g++) begin
         row_sum_in = row_sum_in + SUM_W'(grp_sum_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      new_row_ff <= new_row_in;
      grp_sum_ff <= grp_sum_in;
      row_sum_ff <= row_sum_in;
   end

   assign new_row = new_row_ff;
   assign row_sum = row_sum_ff;

endmodule

// ===== hw/rtl/ssdu_seq.sv =====
// Sequencer: walks the rows, tracks the update pipeline and hands the
// finished beat to the output register; uses ssdu_pkg.
module ssdu_seq import ssdu_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   output seq_ctrl_type       ctrl,
   output logic [ROW_W-1:0]   rd_row,
   output logic [MOD_W-1:0]   upd_mod,
   output logic [ROW_W-1:0]   wr_row
);

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(ROW_MOD - 1);

   seq_state_type      state_ff, state_in;
   logic [ROW_W-1:0]   rd_row_ff, rd_row_in;
   logic [MOD_W-1:0]   rd_mod_ff, rd_mod_in;
   logic               primed_ff, primed_in;
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [ROW_W-1:0]   s1_row_ff, s2_row_ff;
   logic [MOD_W-1:0]   s1_mod_ff;

   // Next state and controls.
   always_comb begin
      state_in  = state_ff;
      rd_row_in = rd_row_ff;
      rd_mod_in = rd_mod_ff;
      primed_in = primed_ff;
      ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.accept = 1'b1;
               rd_row_in   = '0;
               rd_mod_in   = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            ctrl.rd_en = 1'b1;
            if (rd_row_ff == ROW_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               rd_row_in = rd_row_ff + ROW_W'(1);
               rd_mod_in = (rd_mod_ff == MOD_LAST) ? '0 : rd_mod_ff + MOD_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!(s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.finish = 1'b1;
               primed_in   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ctrl.busy   = (state_ff != ST_IDLE);
      ctrl.wr_en  = s2_valid_ff;
      ctrl.acc_en = s4_valid_ff;
      ctrl.primed = primed_ff;
   end

   // Hold state, counters and pipeline valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         primed_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         primed_ff   <= primed_in;
         s1_valid_ff <= ctrl.rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Carry row tags down the pipeline.
   always_ff @(posedge clock) begin
      rd_row_ff <= rd_row_in;
      rd_mod_ff <= rd_mod_in;
      s1_row_ff <= rd_row_ff;
      s1_mod_ff <= rd_mod_ff;
      s2_row_ff <= s1_row_ff;
   end

   assign rd_row  = rd_row_ff;
   assign upd_mod = s1_mod_ff;
   assign wr_row  = s2_row_ff;

endmodule

// ===== hw/rtl/saturating_state_decay_update_core.sv =====
// Top level of the saturating state decay update core: register port,
// output register, energy accumulator. Uses ssdu_pkg, ssdu_seq, ssdu_state_mem, ssdu_row_unit.
//
// Usage:
//   req_* carries one signed sample per beat (valid/stall). Every sample rewrites all
//   ROWS x COLS hidden states: h' = clamp(floor(dg*h/128) + floor(ig*x/128), -127, 127).
//   rsp_* returns one beat per sample: the sum of |h| over the grid and the step index.
//   csr_* is an APB-style port: decay_base at 0x0, input_base at 0x4 (7 bits each).
// Timing:
//   One row of COLS states is read, updated and written back per cycle through the
//   shared row unit. After the last row read the sequencer drains the update pipeline,
//   then loads the result into the output register once it is free, raising rsp_valid.
//   req_stall is high from acceptance until the sequencer is idle again, so a new
//   sample is taken only after the last one has been handed to the output register.
// Reset:
//   Synchronous, active high. Registers return to 70 and 20. The grid reads as zero
//   until the first sample has rewritten it, so no clearing pass is needed.
// Back-pressure:
//   The result sits in an output register; the next sample is accepted and processed
//   while it waits. Should a second result finish first, the core holds it until
//   the waiting beat is taken.
module saturating_state_decay_update_core import ssdu_pkg::*; #(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF,
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int SUM_W = $clog2(COLS * STATE_MAX + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [7:0]      req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ENERGY_W-1:0]    rsp_energy,
   output logic [7:0]             rsp_step_index,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   seq_ctrl_type              ctrl;
   logic                      out_free;
   logic [ROW_W-1:0]          rd_row, wr_row;
   logic [MOD_W-1:0]          upd_mod;
   logic [COLS*STATE_W-1:0]   h_row, new_row;
   logic [SUM_W-1:0]          row_sum;
   reg_idx_type               csr_idx;
   logic                      csr_wr;

   logic [GAIN_W-1:0]         decay_ff, decay_in;
   logic [GAIN_W-1:0]         input_ff, input_in;
   logic signed [7:0]         sample_ff;
   logic [7:0]                step_ff;
   logic [ENERGY_W-1:0]       acc_ff, acc_in;
   logic [ENERGY_W:0]         acc_sum;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ENERGY_W-1:0]       rsp_energy_ff;
   logic [7:0]                rsp_step_ff;

   // Register writes and reads.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[2]);

   always_comb begin
      decay_in   = decay_ff;
      input_in   = input_ff;
      csr_prdata = '0;
      unique case (csr_idx)
         REG_DECAY_BASE: begin
            csr_prdata = {25'd0, decay_ff};
            if (csr_wr) decay_in = csr_pwdata[GAIN_W-1:0];
         end
         REG_INPUT_BASE: begin
            csr_prdata = {25'd0, input_ff};
            if (csr_wr) input_in = csr_pwdata[GAIN_W-1:0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
         input_ff <= INPUT_RESET;
      end else begin
         decay_ff <= decay_in;
         input_ff <= input_in;
      end
   end

   // Sequencer.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = ctrl.busy;

   ssdu_seq #(.ROWS(ROWS)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .rd_row    (rd_row),
      .upd_mod   (upd_mod),
      .wr_row    (wr_row)
   );

   ssdu_state_mem #(.ROWS(ROWS), .COLS(COLS)) u_mem (
      .clock   (clock),
      .rd_en   (ctrl.rd_en),
      .rd_row  (rd_row),
      .wr_en   (ctrl.wr_en),
      .wr_row  (wr_row),
      .wr_data (new_row),
      .rd_data (h_row)
   );

   ssdu_row_unit #(.COLS(COLS)) u_row (
      .clock      (clock),
      .h_row      (h_row),
      .primed     (ctrl.primed),
      .decay_base (decay_ff),
      .input_base (input_ff),
      .sample     (sample_ff),
      .upd_mod    (upd_mod),
      .new_row    (new_row),
      .row_sum    (row_sum)
   );

   // Latch the sample and its step index on acceptance.
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         sample_ff <= req_sample;
         step_ff   <= step_lookup(req_sample);
      end
   end

   // Accumulate row sums, saturating at the field maximum.
   assign acc_sum = {1'b0, acc_ff} + (ENERGY_W + 1)'(row_sum);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.accept) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_sum[ENERGY_W] ? '1 : acc_sum[ENERGY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Output register: load on finish, drop when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_energy_ff <= acc_ff;
         rsp_step_ff   <= step_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_energy     = rsp_energy_ff;
   assign rsp_step_index = rsp_step_ff;

endmodule
